/* rtl/core/iouds_pkg.sv */
`default_nettype none

package iouds_pkg;

	// Fixed widths of the time base and the configuration register.
	localparam int TIME_W = 32;
	localparam int SUP_W  = 8;
	// Width of a hold or keep window in ms (255 * 1000 + 1000 fits in 18 bits).
	localparam int HOLD_W = 18;

	// Motion must persist this long before a frame is reported.
	localparam int unsigned PERSIST_MS = 3000;
	localparam int unsigned MS_PER_S   = 1000;

	// Reset value of the suppression window in seconds.
	localparam logic [SUP_W-1:0] SUPPRESS_RESET = 8'd5;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_INTER,
		ST_MULT,
		ST_CMP,
		ST_WRITE
	} iouds_state_t;

endpackage

`default_nettype wire

/* rtl/core/iou_duplicate_suppressor_core.sv */
`default_nettype none

// Temporal duplicate suppression of motion rectangles by intersection over union.
// Input transaction: start is sampled with frame_start, has_rect, timestamp_ms and
// the rectangle; it is taken at a rising edge where start is high and busy is low.
// Result transaction: done is high for exactly one cycle with abnormal and the echoed
// rectangle (zero when the item carried none). The receiver cannot stall; every
// input transaction gives exactly one result.
// Timing: each item scans the whole entry table with one shared multiplier and a
// single read port on the entry memory: per entry an intersection, a multiply and a
// compare step, plus a setup and a table-update step. busy stays high until the item
// is through; done is high in the first cycle in which busy is low, and a new item
// may be started in that same cycle. No new item is taken while busy is high.
// Configuration: cfg_wr_en writes cfg_wr_data into the suppression window (seconds)
// at once; write it only while the block is idle.
// Reset: arst_n clears the motion tracking and all table valid bits and sets the
// suppression window to 5 s. The entry memory itself is not cleared.
module iou_duplicate_suppressor_core
	import iouds_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int COORD_BITS  = 12
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire [SUP_W-1:0]        cfg_wr_data,
	input  wire                    start,
	output logic                   busy,
	input  wire                    frame_start,
	input  wire                    has_rect,
	input  wire [TIME_W-1:0]       timestamp_ms,
	input  wire [COORD_BITS-1:0]   rect_x,
	input  wire [COORD_BITS-1:0]   rect_y,
	input  wire [COORD_BITS-1:0]   rect_w,
	input  wire [COORD_BITS-1:0]   rect_h,
	output logic                   done,
	output logic                   abnormal,
	output logic [COORD_BITS-1:0]  out_x,
	output logic [COORD_BITS-1:0]  out_y,
	output logic [COORD_BITS-1:0]  out_w,
	output logic [COORD_BITS-1:0]  out_h
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CB     = COORD_BITS;
	localparam int OP_W   = CB + 1;
	localparam int PROD_W = 2 * OP_W;
	localparam int WORD_W = 4 * CB + TIME_W;

	iouds_state_t state_q, state_d;

	// Configuration and motion tracking.
	logic [SUP_W-1:0]   suppress_q;
	logic               motion_active_q;
	logic [TIME_W-1:0]  motion_begin_q;
	logic               reporting_q;

	// Latched input item.
	logic               start_q, has_q;
	logic [TIME_W-1:0]  now_q;
	logic [CB-1:0]      x_q, y_q, w_q, h_q;

	// Table storage.
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [WORD_W-1:0]      mem [TABLE_DEPTH];
	logic [WORD_W-1:0]      rd_q;
	logic [IDX_W-1:0]       rd_addr_q;
	logic                   mem_we;
	logic [IDX_W-1:0]       slot;

	// Scan state.
	logic [IDX_W-1:0]   idx_q;
	logic [HOLD_W-1:0]  hold_q, keep_q;
	logic [OP_W-1:0]    iw_q, ih_q;
	logic [PROD_W-1:0]  area_a_q, area_b_q, inter_q;
	logic               near_q, sup_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q, old_idx_q;
	logic [TIME_W-1:0]  old_age_q;

	// Result register.
	logic               done_q, abnormal_q;
	logic [CB-1:0]      ox_q, oy_q, ow_q, oh_q;

	logic accept, last, report_new;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign last   = (idx_q == IDX_W'(TABLE_DEPTH - 1));

	// Fields of the entry read from memory.
	logic [CB-1:0]     bx, by, bw, bh;
	logic [TIME_W-1:0] btime;
	assign bx    = rd_q[CB-1:0];
	assign by    = rd_q[2*CB-1:CB];
	assign bw    = rd_q[3*CB-1:2*CB];
	assign bh    = rd_q[4*CB-1:3*CB];
	assign btime = rd_q[WORD_W-1:4*CB];

	// Hold window in ms; keep window is one second longer.
	logic [HOLD_W-1:0] hold_c, keep_c;
	assign hold_c = HOLD_W'(suppress_q) * HOLD_W'(MS_PER_S);
	assign keep_c = hold_c + HOLD_W'(MS_PER_S);

	// Intersection extent of the item and the current entry.
	logic [OP_W-1:0] ax2, bx2, ay2, by2, lx, ly, rx, ry, iw_c, ih_c;
	always_comb begin
		ax2  = OP_W'(x_q) + OP_W'(w_q);
		bx2  = OP_W'(bx) + OP_W'(bw);
		ay2  = OP_W'(y_q) + OP_W'(h_q);
		by2  = OP_W'(by) + OP_W'(bh);
		lx   = (x_q > bx) ? OP_W'(x_q) : OP_W'(bx);
		ly   = (y_q > by) ? OP_W'(y_q) : OP_W'(by);
		rx   = (ax2 < bx2) ? ax2 : bx2;
		ry   = (ay2 < by2) ? ay2 : by2;
		iw_c = (rx > lx) ? rx - lx : '0;
		ih_c = (ry > ly) ? ry - ly : '0;
	end

	// Age of the current entry and its expiry and hold tests.
	logic [TIME_W-1:0] age_c;
	logic              valid_i, valid_after, near_c;
	assign age_c       = now_q - btime;
	assign valid_i     = valid_q[idx_q];
	assign valid_after = valid_i && (age_c < TIME_W'(keep_q));
	assign near_c      = valid_after && (age_c < TIME_W'(hold_q));

	// Shared multiplier: item area, entry area, then intersection area.
	logic [OP_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	always_comb begin
		case (state_q)
			ST_PREP: begin
				mul_a = OP_W'(w_q);
				mul_b = OP_W'(h_q);
			end
			ST_INTER: begin
				mul_a = OP_W'(bw);
				mul_b = OP_W'(bh);
			end
			ST_MULT: begin
				mul_a = iw_q;
				mul_b = ih_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// IOU above one half: 2*inter > a + b - inter, i.e. 3*inter > a + b.
	logic [PROD_W+1:0] tri_inter, area_sum;
	logic              overlap_c;
	assign tri_inter = (PROD_W+2)'({inter_q, 1'b0}) + (PROD_W+2)'(inter_q);
	assign area_sum  = (PROD_W+2)'(area_a_q) + (PROD_W+2)'(area_b_q);
	assign overlap_c = tri_inter > area_sum;

	// New entry goes to the first free slot, else over the oldest entry.
	assign report_new = has_q && reporting_q && !sup_q;
	assign slot       = free_found_q ? free_idx_q : old_idx_q;
	assign mem_we     = (state_q == ST_WRITE) && report_new;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state: setup, three steps per entry, table update.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_PREP;
			ST_PREP:  state_d = ST_INTER;
			ST_INTER: state_d = ST_MULT;
			ST_MULT:  state_d = ST_CMP;
			ST_CMP:   state_d = last ? ST_WRITE : ST_INTER;
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suppress_q <= SUPPRESS_RESET;
		end else if (cfg_wr_en) begin
			suppress_q <= cfg_wr_data;
		end
	end

	// Latch the input item on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= frame_start;
			has_q   <= has_rect;
			now_q   <= timestamp_ms;
			x_q     <= rect_x;
			y_q     <= rect_y;
			w_q     <= rect_w;
			h_q     <= rect_h;
		end
	end

	// Motion run tracking and the reporting decision of the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_active_q <= 1'b0;
			motion_begin_q  <= '0;
			reporting_q     <= 1'b0;
		end else if (state_q == ST_PREP && start_q) begin
			if (!has_q) begin
				motion_active_q <= 1'b0;
				reporting_q     <= 1'b0;
			end else if (!motion_active_q) begin
				motion_active_q <= 1'b1;
				motion_begin_q  <= now_q;
				reporting_q     <= 1'b0;
			end else begin
				reporting_q <= (now_q - motion_begin_q) >= TIME_W'(PERSIST_MS);
			end
		end
	end

	// Scan counters and table valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_addr_q <= '0;
			valid_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q     <= '0;
					rd_addr_q <= '0;
				end
				ST_INTER: begin
					valid_q[idx_q] <= valid_after;
					rd_addr_q      <= last ? '0 : idx_q + IDX_W'(1);
				end
				ST_CMP: begin
					if (!last) idx_q <= idx_q + IDX_W'(1);
				end
				ST_WRITE: begin
					if (report_new) valid_q[slot] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Scan datapath: windows, products and slot selection.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				hold_q       <= hold_c;
				keep_q       <= keep_c;
				area_a_q     <= prod;
				sup_q        <= 1'b0;
				free_found_q <= 1'b0;
				free_idx_q   <= '0;
				old_idx_q    <= '0;
				old_age_q    <= '0;
			end
			ST_INTER: begin
				iw_q     <= iw_c;
				ih_q     <= ih_c;
				area_b_q <= prod;
				near_q   <= near_c;
				if (!valid_after && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_q;
				end
				if (idx_q == '0 || age_c > old_age_q) begin
					old_age_q <= age_c;
					old_idx_q <= idx_q;
				end
			end
			ST_MULT: begin
				inter_q <= prod;
			end
			ST_CMP: begin
				if (near_q && overlap_c) sup_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot] <= {now_q, h_q, w_q, y_q, x_q};
		end
		rd_q <= mem[rd_addr_q];
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WRITE);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			abnormal_q <= report_new;
			ox_q       <= has_q ? x_q : '0;
			oy_q       <= has_q ? y_q : '0;
			ow_q       <= has_q ? w_q : '0;
			oh_q       <= has_q ? h_q : '0;
		end
	end

	assign done     = done_q;
	assign abnormal = abnormal_q;
	assign out_x    = ox_q;
	assign out_y    = oy_q;
	assign out_w    = ow_q;
	assign out_h    = oh_q;

endmodule

`default_nettype wire

/* rtl/core/iouds_checker.sv */
`default_nettype none

// Port-level checks of the command handshake and result strobe.
module iouds_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done
);

	// A result is never shown while an item is still being worked on.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
	else $error("result strobe while busy");

	// The result strobe lasts a single cycle per transaction.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
	else $error("result strobe longer than one cycle");

	// Busy only rises after an accepted transaction.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
	else $error("busy rose without a start");

	// Every finished item delivers its result as busy drops.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
	else $error("item finished without a result");

endmodule

bind iou_duplicate_suppressor_core iouds_checker u_iouds_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
